// ----- hdl/hoi_pkg.sv -----
// ----------------------------------------------------------------------------
// hoi_pkg
// types and constants shared by the holonomic odometry integrator
// ----------------------------------------------------------------------------
package hoi_pkg;

	localparam logic [1:0] CMD_SET  = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;

	localparam logic [2:0] REG_LIM_FWD  = 3'd0;
	localparam logic [2:0] REG_LIM_LAT  = 3'd1;
	localparam logic [2:0] REG_LIM_TURN = 3'd2;
	localparam logic [2:0] REG_PERIOD   = 3'd3;
	localparam logic [2:0] REG_STOP     = 3'd4;
	localparam logic [2:0] REG_EMERG    = 3'd5;

	localparam logic signed [35:0] ANG_PI      = 36'sd843314857;
	localparam logic signed [35:0] ANG_TWO_PI  = 36'sd1686629713;
	localparam logic signed [35:0] ANG_HALF_PI = 36'sd421657428;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] forward_cmd;
		logic signed [15:0] lateral_cmd;
		logic signed [15:0] turn_cmd;
		logic [7:0]         mode_cmd;
	} hoi_in_t;

	typedef struct packed {
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
		logic signed [31:0] heading;
		logic signed [15:0] vel_forward;
		logic signed [15:0] vel_lateral;
		logic signed [15:0] vel_turn;
		logic [7:0]         mode_out;
	} hoi_out_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} hoi_cfg_t;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		case (i)
			5'd0:  atan_q28 = 32'sd210828714;
			5'd1:  atan_q28 = 32'sd124459457;
			5'd2:  atan_q28 = 32'sd65760959;
			5'd3:  atan_q28 = 32'sd33381290;
			5'd4:  atan_q28 = 32'sd16755422;
			5'd5:  atan_q28 = 32'sd8385879;
			5'd6:  atan_q28 = 32'sd4193963;
			5'd7:  atan_q28 = 32'sd2097109;
			5'd8:  atan_q28 = 32'sd1048571;
			5'd9:  atan_q28 = 32'sd524287;
			5'd10: atan_q28 = 32'sd262144;
			5'd11: atan_q28 = 32'sd131072;
			5'd12: atan_q28 = 32'sd65536;
			5'd13: atan_q28 = 32'sd32768;
			5'd14: atan_q28 = 32'sd16384;
			5'd15: atan_q28 = 32'sd8192;
			5'd16: atan_q28 = 32'sd4096;
			5'd17: atan_q28 = 32'sd2048;
			5'd18: atan_q28 = 32'sd1024;
			5'd19: atan_q28 = 32'sd512;
			5'd20: atan_q28 = 32'sd256;
			5'd21: atan_q28 = 32'sd128;
			5'd22: atan_q28 = 32'sd64;
			5'd23: atan_q28 = 32'sd32;
			default: atan_q28 = 32'sd0;
		endcase
	endfunction

endpackage

// ----- hdl/hoi_cordic.sv -----
// ----------------------------------------------------------------------------
// hoi_cordic
// iterative cordic, one rotation step per cycle, cos and sin in q1.15
// ----------------------------------------------------------------------------
module hoi_cordic import hoi_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [15:0] cos_q15,
	output logic signed [15:0] sin_q15
);

	localparam int IW = $clog2(STEPS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} st_t;

	st_t state_q;
	logic [IW-1:0] i_q;
	logic signed [35:0] x_q, y_q, z_q;
	logic neg_q;
	logic signed [35:0] z0, z1, xs, ys, xr, yr, xrnd, yrnd;
	logic neg0;
	logic [4:0] i5;

	assign i5 = 5'(i_q);
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_comb begin
		z0 = 36'(angle);
		neg0 = 1'b0;
		if (z0 > ANG_PI) z0 = z0 - ANG_TWO_PI;
		if (z0 < -ANG_PI) z0 = z0 + ANG_TWO_PI;
		z1 = z0;
		if (z0 > ANG_HALF_PI) begin
			z1 = z0 - ANG_PI;
			neg0 = 1'b1;
		end else if (z0 < -ANG_HALF_PI) begin
			z1 = z0 + ANG_PI;
			neg0 = 1'b1;
		end
	end

	function automatic logic signed [15:0] rnd_sat(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = (v + 36'sd16384) >>> 15;
		if (r > 36'sd32767) rnd_sat = 16'sd32767;
		else if (r < -36'sd32768) rnd_sat = -16'sd32768;
		else rnd_sat = 16'(r);
	endfunction

	assign xr = neg_q ? -x_q : x_q;
	assign yr = neg_q ? -y_q : y_q;
	assign xrnd = xr;
	assign yrnd = yr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						x_q <= 36'(CORDIC_GAIN);
						y_q <= '0;
						z_q <= z1;
						neg_q <= neg0;
						i_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (z_q >= 0) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - 36'(atan_q28(i5));
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + 36'(atan_q28(i5));
					end
					if (i_q == IW'(STEPS - 1)) state_q <= ST_OUT;
					i_q <= i_q + 1'b1;
				end
				ST_OUT: begin
					cos_q15 <= rnd_sat(xrnd);
					sin_q15 <= rnd_sat(yrnd);
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_OUT)
		else $error("cordic done without finishing");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> i_q < IW'(STEPS))
		else $error("cordic step count overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> state_q == ST_RUN)
		else $error("cordic did not start");

endmodule

// ----- hdl/holonomic_odometry_integrator_unit.sv -----
// ----------------------------------------------------------------------------
// holonomic_odometry_integrator_unit
// dead reckoning odometry: set clamps or zeroes velocities, tick integrates pose
//
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | hoi_in_t
//  out     | output    | out_valid/stall | hoi_out_t
//  cfg     | input     | valid/ready     | hoi_cfg_t
//
//  set, read go straight to output; tick runs cordic, multiplies, pose update
//  tick time is set by the cordic loop and one shared 32x25 multiplier
//  reset clears pose and velocities, loads register defaults
//  a result waits in an output register while out_stall is high
//  the next item may start while a result waits; a finished item waits for it
// ----------------------------------------------------------------------------
module holonomic_odometry_integrator_unit import hoi_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  hoi_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output hoi_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  hoi_cfg_t cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_COS, ST_M1, ST_M2, ST_M3, ST_M4, ST_SUMX, ST_SUMY,
		ST_M5, ST_M6, ST_M7, ST_POS, ST_HEAD, ST_OUT
	} st_t;

	st_t state_q;
	logic [14:0] lim_f_q, lim_l_q, lim_t_q;
	logic [23:0] period_q;
	logic [7:0] stop_q, emerg_q;
	logic signed [47:0] px_q, py_q;
	logic signed [31:0] hd_q;
	logic signed [15:0] vf_q, vl_q, vt_q;
	logic [7:0] mode_q;
	logic signed [31:0] p1_q, p2_q, sx_q, sy_q;
	logic signed [56:0] dx_q, dy_q;
	logic signed [39:0] dh_q;
	logic signed [31:0] ma;
	logic signed [24:0] mb;
	logic signed [56:0] mp;
	logic cstart, cdone;
	logic signed [15:0] cc, cs;
	hoi_out_t out_q;
	logic out_free;

	hoi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart), .angle(hd_q),
		.done(cdone), .cos_q15(cc), .sin_q15(cs)
	);

	assign cstart = (state_q == ST_COS);
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid || !out_stall;

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_M1: begin ma = 32'(vf_q); mb = 25'(cc); end
			ST_M2: begin ma = 32'(vl_q); mb = 25'(cs); end
			ST_M3: begin ma = 32'(vf_q); mb = 25'(cs); end
			ST_M4: begin ma = 32'(vl_q); mb = 25'(cc); end
			ST_M5: begin ma = sx_q; mb = 25'(period_q); end
			ST_M6: begin ma = sy_q; mb = 25'(period_q); end
			ST_M7: begin ma = 32'(vt_q); mb = 25'(period_q); end
			default: ;
		endcase
	end
	assign mp = 57'(ma) * 57'(mb);

	function automatic logic signed [15:0] clampv(input logic signed [15:0] v,
			input logic [14:0] lim);
		logic signed [16:0] l, w;
		l = 17'({2'b00, lim});
		w = 17'(v);
		if (w > l) clampv = 16'(l);
		else if (w < -l) clampv = 16'(-l);
		else clampv = v;
	endfunction

	function automatic logic signed [47:0] addsat(input logic signed [47:0] p,
			input logic signed [56:0] d);
		logic signed [57:0] r, s;
		r = (58'(d) + 58'sd67108864) >>> 27;
		s = 58'(p) + r;
		if (s > 58'sd140737488355327) addsat = 48'sh7fffffffffff;
		else if (s < -58'sd140737488355328) addsat = 48'sh800000000000;
		else addsat = 48'(s);
	endfunction

	logic signed [35:0] hn;
	always_comb begin
		hn = 36'(hd_q) + 36'((dh_q + 40'sd128) >>> 8);
		if (hn > ANG_PI) hn = hn - ANG_TWO_PI;
		if (hn < -ANG_PI) hn = hn + ANG_TWO_PI;
		if (hn > 36'sd2147483647) hn = 36'sd2147483647;
		if (hn < -36'sd2147483648) hn = -36'sd2147483648;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_f_q <= 15'd2458;
			lim_l_q <= 15'd1638;
			lim_t_q <= 15'd6144;
			period_q <= 24'd16777;
			stop_q <= 8'd0;
			emerg_q <= 8'd255;
		end else if (cfg_valid) begin
			unique case (cfg_data.index)
				REG_LIM_FWD:  lim_f_q <= cfg_data.data[14:0];
				REG_LIM_LAT:  lim_l_q <= cfg_data.data[14:0];
				REG_LIM_TURN: lim_t_q <= cfg_data.data[14:0];
				REG_PERIOD:   period_q <= cfg_data.data[23:0];
				REG_STOP:     stop_q <= cfg_data.data[7:0];
				REG_EMERG:    emerg_q <= cfg_data.data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			out_q <= '0;
			px_q <= '0;
			py_q <= '0;
			hd_q <= '0;
			vf_q <= '0;
			vl_q <= '0;
			vt_q <= '0;
			mode_q <= '0;
		end else begin
			if (state_q == ST_OUT && out_free) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_data.command == CMD_SET) begin
							mode_q <= in_data.mode_cmd;
							if (in_data.mode_cmd == stop_q || in_data.mode_cmd == emerg_q) begin
								vf_q <= '0;
								vl_q <= '0;
								vt_q <= '0;
							end else begin
								vf_q <= clampv(in_data.forward_cmd, lim_f_q);
								vl_q <= clampv(in_data.lateral_cmd, lim_l_q);
								vt_q <= clampv(in_data.turn_cmd, lim_t_q);
							end
							state_q <= ST_OUT;
						end else if (in_data.command == CMD_TICK) begin
							state_q <= ST_COS;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_COS: state_q <= ST_M1;
				ST_M1: begin
					if (cdone) begin
						p1_q <= 32'(mp);
						state_q <= ST_M2;
					end
				end
				ST_M2: begin p2_q <= 32'(mp); state_q <= ST_M3; end
				ST_M3: begin sx_q <= p1_q - p2_q; p1_q <= 32'(mp); state_q <= ST_M4; end
				ST_M4: begin p2_q <= 32'(mp); state_q <= ST_SUMY; end
				ST_SUMY: begin sy_q <= p1_q + p2_q; state_q <= ST_M5; end
				ST_M5: begin dx_q <= mp; state_q <= ST_M6; end
				ST_M6: begin dy_q <= mp; state_q <= ST_M7; end
				ST_M7: begin dh_q <= 40'(mp); state_q <= ST_POS; end
				ST_POS: begin
					px_q <= addsat(px_q, dx_q);
					py_q <= addsat(py_q, dy_q);
					state_q <= ST_HEAD;
				end
				ST_HEAD: begin hd_q <= 32'(hn); state_q <= ST_OUT; end
				ST_OUT: begin
					if (out_free) begin
						out_q <= '{pos_x: px_q, pos_y: py_q, heading: hd_q,
							vel_forward: vf_q, vel_lateral: vl_q, vel_turn: vt_q,
							mode_out: mode_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_data = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_valid) |=> out_valid)
		else $error("finished item not shown");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(out_q))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> state_q != ST_IDLE)
		else $error("accepted item dropped");

endmodule

// ----- tb/holonomic_odometry_integrator_unit_checker.sv -----
// ----------------------------------------------------------------------------
// holonomic_odometry_integrator_unit_checker
// watches the in, out and cfg channels, keeps its own copy of the pose and
// register state, predicts the result of every accepted item and compares
// each accepted result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module holonomic_odometry_integrator_unit_checker import hoi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_stall,
	input  hoi_in_t  in_data,
	input  logic     out_valid,
	input  logic     out_stall,
	input  hoi_out_t out_data,
	input  logic     cfg_valid,
	input  logic     cfg_ready,
	input  hoi_cfg_t cfg_data,
	output int       fail_count,
	output int       pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint POS_HI = 64'sd140737488355327;
	localparam longint POS_LO = -64'sd140737488355328;

	longint lim_fwd, lim_lat, lim_turn, period, stop_val, emerg_val;
	longint pose_x, pose_y, pose_hdg, spd_f, spd_l, spd_t, mode_val;
	hoi_out_t pose_queue[$];

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint atan_entry(int i);
		longint tbl[24] = '{210828714, 124459457, 65760959, 33381290, 16755422,
			8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
			32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
		return tbl[i];
	endfunction

	task automatic rotate_unit(input longint ang, output longint c, output longint s);
		longint x, y, z, t;
		bit flip;
		x = 652032874;
		y = 0;
		z = ang;
		flip = 0;
		if (z > 843314857) z -= 1686629713;
		if (z < -843314857) z += 1686629713;
		if (z > 421657428) begin
			z -= 843314857;
			flip = 1;
		end else if (z < -421657428) begin
			z += 843314857;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				t = x - shr(y, i);
				y = y + shr(x, i);
				z -= atan_entry(i);
			end else begin
				t = x + shr(y, i);
				y = y - shr(x, i);
				z += atan_entry(i);
			end
			x = t;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = clip(shr(x + 16384, 15), -32768, 32767);
		s = clip(shr(y + 16384, 15), -32768, 32767);
	endtask

	task automatic advance_pose(input hoi_in_t it);
		longint c, s, dx, dy;
		hoi_out_t r;
		if (it.command == CMD_SET) begin
			mode_val = longint'(it.mode_cmd);
			if (mode_val == stop_val || mode_val == emerg_val) begin
				spd_f = 0;
				spd_l = 0;
				spd_t = 0;
			end else begin
				spd_f = clip(longint'(it.forward_cmd), -lim_fwd, lim_fwd);
				spd_l = clip(longint'(it.lateral_cmd), -lim_lat, lim_lat);
				spd_t = clip(longint'(it.turn_cmd), -lim_turn, lim_turn);
			end
		end else if (it.command == CMD_TICK) begin
			rotate_unit(pose_hdg, c, s);
			dx = shr((spd_f * c - spd_l * s) * period + (64'sd1 <<< 26), 27);
			dy = shr((spd_f * s + spd_l * c) * period + (64'sd1 <<< 26), 27);
			pose_x = clip(pose_x + dx, POS_LO, POS_HI);
			pose_y = clip(pose_y + dy, POS_LO, POS_HI);
			pose_hdg += shr(spd_t * period + 128, 8);
			if (pose_hdg > 843314857) pose_hdg -= 1686629713;
			if (pose_hdg < -843314857) pose_hdg += 1686629713;
			pose_hdg = clip(pose_hdg, -64'sd2147483648, 64'sd2147483647);
		end
		r.pos_x = pose_x[47:0];
		r.pos_y = pose_y[47:0];
		r.heading = pose_hdg[31:0];
		r.vel_forward = spd_f[15:0];
		r.vel_lateral = spd_l[15:0];
		r.vel_turn = spd_t[15:0];
		r.mode_out = mode_val[7:0];
		pose_queue.push_back(r);
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		hoi_out_t w;
		if (!arst_n) begin
			lim_fwd <= 2458;
			lim_lat <= 1638;
			lim_turn <= 6144;
			period <= 16777;
			stop_val <= 0;
			emerg_val <= 255;
			pose_x = 0;
			pose_y = 0;
			pose_hdg = 0;
			spd_f = 0;
			spd_l = 0;
			spd_t = 0;
			mode_val = 0;
			fail_count = 0;
			pose_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_LIM_FWD:  lim_fwd <= longint'(cfg_data.data[14:0]);
					REG_LIM_LAT:  lim_lat <= longint'(cfg_data.data[14:0]);
					REG_LIM_TURN: lim_turn <= longint'(cfg_data.data[14:0]);
					REG_PERIOD:   period <= longint'(cfg_data.data[23:0]);
					REG_STOP:     stop_val <= longint'(cfg_data.data[7:0]);
					REG_EMERG:    emerg_val <= longint'(cfg_data.data[7:0]);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pose_queue.size() == 0) begin
					report("unexpected item", out_data[63:0], 64'd0);
				end else begin
					w = pose_queue.pop_front();
					if (out_data.pos_x !== w.pos_x)
						report("pos_x", 64'(out_data.pos_x), 64'(w.pos_x));
					if (out_data.pos_y !== w.pos_y)
						report("pos_y", 64'(out_data.pos_y), 64'(w.pos_y));
					if (out_data.heading !== w.heading)
						report("heading", 64'(out_data.heading), 64'(w.heading));
					if (out_data.vel_forward !== w.vel_forward)
						report("vel_forward", 64'(out_data.vel_forward), 64'(w.vel_forward));
					if (out_data.vel_lateral !== w.vel_lateral)
						report("vel_lateral", 64'(out_data.vel_lateral), 64'(w.vel_lateral));
					if (out_data.vel_turn !== w.vel_turn)
						report("vel_turn", 64'(out_data.vel_turn), 64'(w.vel_turn));
					if (out_data.mode_out !== w.mode_out)
						report("mode_out", 64'(out_data.mode_out), 64'(w.mode_out));
				end
			end
			if (in_valid && !in_stall) advance_pose(in_data);
		end
		pending_count = pose_queue.size();
	end
endmodule

// ----- tb/holonomic_odometry_integrator_unit_test.sv -----
// ----------------------------------------------------------------------------
// holonomic_odometry_integrator_unit_test
// drives directed and random set, tick and read items through the odometry
// unit under random gaps and stalls, across several register settings
// ----------------------------------------------------------------------------
module holonomic_odometry_integrator_unit_test;
	import hoi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	hoi_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	hoi_out_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	hoi_cfg_t cfg_data = '0;
	int fail_count, pending_count;
	longint cycle_count = 0;
	bit sending_done = 0;
	bit hold_off = 0;

	holonomic_odometry_integrator_unit i_dut (.*);
	holonomic_odometry_integrator_unit_checker i_checker (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			gap = $urandom_range(0, 13);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap != 0) begin
				out_stall <= 1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 0;
		end
	end

	task automatic send_item(input hoi_in_t it);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 2) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_data <= '{index: idx, data: val};
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic hoi_in_t mk(logic [1:0] c, logic [15:0] f, logic [15:0] l,
			logic [15:0] t, logic [7:0] m);
		hoi_in_t r;
		r.command = c;
		r.forward_cmd = f;
		r.lateral_cmd = l;
		r.turn_cmd = t;
		r.mode_cmd = m;
		return r;
	endfunction

	function automatic hoi_in_t random_item;
		logic [1:0] c;
		int k;
		k = $urandom_range(0, 19);
		c = (k < 6) ? CMD_SET : (k < 17) ? CMD_TICK : (k < 19) ? CMD_READ : CMD_SPARE;
		return mk(c, 16'($urandom), 16'($urandom), 16'($urandom),
			($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 2) * 127) : 8'($urandom));
	endfunction

	task automatic random_phase(input int n);
		repeat (n) send_item(random_item());
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed extremes
		send_item(mk(CMD_READ, '0, '0, '0, '0));
		send_item(mk(CMD_SET, 16'h7fff, 16'h8000, 16'h7fff, 8'd1));
		send_item(mk(CMD_TICK, '0, '0, '0, '0));
		send_item(mk(CMD_TICK, '0, '0, '0, '0));
		send_item(mk(CMD_SET, 16'h8000, 16'h7fff, 16'h8000, 8'd2));
		send_item(mk(CMD_TICK, '0, '0, '0, '0));
		send_item(mk(CMD_SPARE, 16'hffff, 16'hffff, 16'hffff, 8'hff));
		send_item(mk(CMD_SET, 16'h7fff, 16'h7fff, 16'h7fff, 8'd0));
		send_item(mk(CMD_TICK, '0, '0, '0, '0));
		send_item(mk(CMD_SET, 16'h7fff, 16'h7fff, 16'h7fff, 8'hff));
		send_item(mk(CMD_SET, 16'h0100, 16'hff00, 16'h1000, 8'h80));
		repeat (6) send_item(mk(CMD_TICK, '0, '0, '0, '0));
		drain();
		// fast spin and long steps, exercise wrap and saturation
		write_reg(REG_LIM_FWD, 32'h7fff);
		write_reg(REG_LIM_LAT, 32'h7fff);
		write_reg(REG_LIM_TURN, 32'h7fff);
		write_reg(REG_PERIOD, 32'hffffff);
		write_reg(REG_STOP, 32'd5);
		write_reg(REG_EMERG, 32'd6);
		write_reg(REG_UNUSED, 32'hffffffff);
		send_item(mk(CMD_SET, 16'h7fff, 16'h7fff, 16'h7fff, 8'd0));
		repeat (4) send_item(mk(CMD_TICK, '0, '0, '0, '0));
		send_item(mk(CMD_SET, 16'h8000, 16'h8000, 16'h8000, 8'd5));
		send_item(mk(CMD_SET, 16'h8000, 16'h8000, 16'h8000, 8'd6));
		drain();
		random_phase(500);
		hold_off = 1;
		random_phase(300);
		write_reg(REG_LIM_FWD, 32'd0);
		write_reg(REG_LIM_LAT, 32'd0);
		write_reg(REG_LIM_TURN, 32'd0);
		write_reg(REG_PERIOD, 32'd1);
		write_reg(REG_STOP, 32'd254);
		write_reg(REG_EMERG, 32'd127);
		random_phase(300);
		write_reg(REG_LIM_FWD, 32'h7fff);
		write_reg(REG_LIM_LAT, 32'h5555);
		write_reg(REG_LIM_TURN, 32'h7fff);
		write_reg(REG_PERIOD, 32'h400000);
		write_reg(REG_STOP, 32'd0);
		write_reg(REG_EMERG, 32'd255);
		random_phase(400);
		write_reg(REG_LIM_FWD, 32'd2458);
		write_reg(REG_LIM_LAT, 32'd1638);
		write_reg(REG_LIM_TURN, 32'd6144);
		write_reg(REG_PERIOD, 32'd16777);
		random_phase(330);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ----- holonomic_odometry_integrator_unit.f -----
hdl/hoi_pkg.sv
hdl/hoi_cordic.sv
hdl/holonomic_odometry_integrator_unit.sv
tb/holonomic_odometry_integrator_unit_checker.sv
tb/holonomic_odometry_integrator_unit_test.sv
